// ===== hw/rtl/cdq_pkg.sv =====
// Shared operation and status codes for the circular deque.
package cdq_pkg;

   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;

   // Operation requested by one input word
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_REAR  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_REAR   = 3'd3,
      KIND_PEEK_FRONT = 3'd4,
      KIND_PEEK_REAR  = 3'd5
   } kind_type;

   // Outcome reported with every result word
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

endpackage

// ===== hw/rtl/cdq_cell.sv =====
// One storage slot of the deque row: holds a word and forwards the read chain.
module cdq_cell #(
   parameter int IDX_W      = 4,
   parameter int WORD_WIDTH = 32,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_idx,
   input  logic [WORD_WIDTH-1:0] wr_data,
   input  logic [IDX_W-1:0]      rd_idx,
   input  logic [WORD_WIDTH-1:0] chain_in,
   output logic [WORD_WIDTH-1:0] chain_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic [WORD_WIDTH-1:0] word_ff;

   // Slot write, selected by index match
   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == MY_IDX)) begin
         word_ff <= wr_data;
      end
   end

   // Read chain: replace the passing word when this slot is addressed
   assign chain_out = (rd_idx == MY_IDX) ? word_ff : chain_in;

endmodule

// ===== hw/rtl/circular_deque.sv =====
// Top level of the circular deque: control, index arithmetic and the slot row.
//
// Double-ended queue of signed words in a ring of DEPTH slots, of which the first
// capacity slots are used. Each request word pushes, pops or peeks at either end
// and returns exactly one response word carrying status, data, count and the
// empty/full flags. A request is taken every cycle while the response register
// is free or being drained and no capacity write or wrap pass is under way, so one
// word per cycle is sustained then; the read goes through a chain of DEPTH slot
// cells within that cycle. A capacity write starts a wrap pass that reduces the
// stored end positions modulo the new capacity, one subtraction per cycle, longest
// for capacity 1; no request is taken meanwhile. Capacity 0 acts as 1, values above
// DEPTH act as DEPTH. Full pushes and empty pops/peeks are rejected with status.
module circular_deque #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cdq_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [WORD_WIDTH-1:0]        req_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cdq_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [WORD_WIDTH-1:0]        rsp_data_out,
   output logic [$clog2(DEPTH+1)-1:0]          rsp_count,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [$clog2(DEPTH+1)-1:0]          csr_wr_data
);

   import cdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'((DEPTH < 16) ? DEPTH : 16);

   // state
   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [IDX_W-1:0] head_mod_ff, head_mod_in, tail_mod_ff, tail_mod_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic             wrap_busy_ff, wrap_busy_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [WORD_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_full_ff, rsp_full_in;

   // slot row access
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_idx;
   logic [IDX_W-1:0]      rd_idx;
   logic [WORD_WIDTH-1:0] chain [DEPTH+1];

   logic accept;
   logic at_front;
   logic is_full_now;
   logic [IDX_W-1:0] head_dec, tail_inc, head_inc, tail_dec;
   logic [CNT_W-1:0] cap_clamped;
   logic [IDX_W-1:0] head_red, tail_red;

   // no request taken while the capacity is written or reduced
   assign req_ready = !csr_wr_en && !wrap_busy_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Clamp the written capacity into 1..DEPTH
   always_comb begin
      priority if (csr_wr_data == '0) begin
         cap_clamped = CNT_W'(1);
      end else if (csr_wr_data > CAP_MAX) begin
         cap_clamped = CAP_MAX;
      end else begin
         cap_clamped = csr_wr_data;
      end
   end

   // Single-wrap neighbors of the reduced end positions
   assign head_inc = ((CNT_W'(head_mod_ff) + CNT_W'(1)) == cap_ff) ? '0
                     : IDX_W'(head_mod_ff + IDX_W'(1));
   assign tail_inc = ((CNT_W'(tail_mod_ff) + CNT_W'(1)) == cap_ff) ? '0
                     : IDX_W'(tail_mod_ff + IDX_W'(1));
   assign head_dec = (head_mod_ff == '0) ? IDX_W'(cap_ff - CNT_W'(1))
                     : IDX_W'(head_mod_ff - IDX_W'(1));
   assign tail_dec = (tail_mod_ff == '0) ? IDX_W'(cap_ff - CNT_W'(1))
                     : IDX_W'(tail_mod_ff - IDX_W'(1));

   // One step of the wrap pass
   assign head_red = (CNT_W'(head_mod_ff) >= cap_ff) ? IDX_W'(CNT_W'(head_mod_ff) - cap_ff)
                     : head_mod_ff;
   assign tail_red = (CNT_W'(tail_mod_ff) >= cap_ff) ? IDX_W'(CNT_W'(tail_mod_ff) - cap_ff)
                     : tail_mod_ff;

   assign at_front    = (req_kind == KIND_POP_FRONT) || (req_kind == KIND_PEEK_FRONT);
   assign rd_idx      = at_front ? head_ff : tail_ff;
   assign is_full_now = (count_ff >= cap_ff);

   // Operation decode and next state
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_mod_in   = head_mod_ff;
      tail_mod_in   = tail_mod_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      wrap_busy_in  = wrap_busy_ff;
      rsp_status_in = STATUS_DONE;
      rsp_data_in   = '0;
      wr_en         = 1'b0;
      wr_idx        = tail_ff;

      if (csr_wr_en) begin
         cap_in       = cap_clamped;
         head_mod_in  = head_ff;
         tail_mod_in  = tail_ff;
         wrap_busy_in = 1'b1;
      end else if (wrap_busy_ff) begin
         head_mod_in  = head_red;
         tail_mod_in  = tail_red;
         wrap_busy_in = (CNT_W'(head_red) >= cap_ff) || (CNT_W'(tail_red) >= cap_ff);
      end else if (accept) begin
         unique case (req_kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
               if (is_full_now) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  wr_en = 1'b1;
                  // moving end rewritten (both if empty); the other keeps its raw slot
                  priority if (count_ff == '0) begin
                     head_in     = '0;
                     tail_in     = '0;
                     head_mod_in = '0;
                     tail_mod_in = '0;
                     wr_idx      = '0;
                  end else if (req_kind == KIND_PUSH_FRONT) begin
                     head_in     = head_dec;
                     head_mod_in = head_dec;
                     wr_idx      = head_dec;
                  end else begin
                     tail_in     = tail_inc;
                     tail_mod_in = tail_inc;
                     wr_idx      = tail_inc;
                  end
                  count_in    = count_ff + CNT_W'(1);
               end
            end
            KIND_POP_FRONT, KIND_POP_REAR, KIND_PEEK_FRONT, KIND_PEEK_REAR: begin
               if (count_ff == '0) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rsp_data_in = chain[DEPTH];
                  if ((req_kind == KIND_POP_FRONT) || (req_kind == KIND_POP_REAR)) begin
                     if (count_ff != CNT_W'(1)) begin
                        if (at_front) begin
                           head_in     = head_inc;
                           head_mod_in = head_inc;
                        end else begin
                           tail_in     = tail_dec;
                           tail_mod_in = tail_dec;
                        end
                     end
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
               // unused codes: report current state only
            end
         endcase
      end

      rsp_empty_in = (count_in == '0);
      rsp_full_in  = (count_in >= cap_ff);
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   // Row of slot cells; the read word runs down the chain
   assign chain[0] = '0;
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cdq_cell #(
         .IDX_W      (IDX_W),
         .WORD_WIDTH (WORD_WIDTH),
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .wr_en     (wr_en),
         .wr_idx    (wr_idx),
         .wr_data   (req_value),
         .rd_idx    (rd_idx),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         head_mod_ff  <= '0;
         tail_mod_ff  <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         wrap_busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         head_mod_ff  <= head_mod_in;
         tail_mod_ff  <= tail_mod_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         wrap_busy_ff <= wrap_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload, loaded on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= count_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_full_ff   <= rsp_full_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_empty_ff;
   assign rsp_is_full  = rsp_full_ff;

   // Checks
   a_reduced_idx: assert property (@(posedge clock) disable iff (reset)
      !wrap_busy_ff |-> (CNT_W'(head_mod_ff) < cap_ff) && (CNT_W'(tail_mod_ff) < cap_ff))
      else $error("end position not reduced below capacity");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      accept && ((req_kind == KIND_PUSH_FRONT) || (req_kind == KIND_PUSH_REAR))
      && (count_ff < cap_ff) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not grow count");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      accept && ((req_kind == KIND_POP_FRONT) || (req_kind == KIND_POP_REAR))
      && (count_ff != '0) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop did not shrink count");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_empty_ff == (rsp_count_ff == '0)))
      else $error("empty flag disagrees with count");

endmodule
